FILE: rtl/tpi_pkg.sv
// Shared types, constants and the CORDIC angle table for the pose integrator.
package tpi_pkg;

	localparam int RATE_WIDTH         = 16;
	localparam int POSITION_WIDTH_DEF = 32;
	localparam int CORDIC_STEPS_DEF   = 16;
	localparam int ATAN_LEN           = 24;
	localparam int ATAN_IDX_WIDTH     = 5;
	localparam int GUARD_SHIFT        = 46 - RATE_WIDTH;
	localparam int ROT_WIDTH          = RATE_WIDTH + GUARD_SHIFT + 3;
	localparam int ANG_WIDTH          = 34;
	localparam int DELTA_WIDTH        = 23;
	localparam int CFG_INDEX_WIDTH    = 3;
	localparam int CFG_DATA_WIDTH     = 32;

	localparam logic [31:0] GAIN_COMP  = 32'h9B74EDA8;
	localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
	localparam logic [15:0] STEP_TIME_RESET = 16'd3277;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_STEP_TIME     = 3'd0,
		CFG_START_X       = 3'd1,
		CFG_START_Y       = 3'd2,
		CFG_START_HEADING = 3'd3,
		CFG_HOLONOMIC     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_SCALE,
		ST_WRITE
	} state_t;

	typedef enum logic [3:0] {
		SC_X_HI_K,
		SC_X_LO_K,
		SC_Y_HI_K,
		SC_X_CHI_T,
		SC_Y_LO_K,
		SC_X_CLO_T,
		SC_Y_CHI_T,
		SC_Y_CLO_T,
		SC_H_HI_P,
		SC_H_LO_P,
		SC_H_DRAIN
	} scale_step_t;

	typedef struct packed {
		logic signed [RATE_WIDTH-1:0] speed_forward;
		logic signed [RATE_WIDTH-1:0] speed_lateral;
		logic signed [RATE_WIDTH-1:0] turn_rate;
		logic                         first_step;
		logic                         last_step;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               end_of_run;
	} pose_t;

	// Arctangent of 2^-i in units of 2 pi / 2^32.
	function automatic logic [31:0] atan_unit(input logic [ATAN_IDX_WIDTH-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/tpi_stream_if.sv
// Valid/ready stream interface carrying one payload item per handshake.
interface tpi_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/trajectory_pose_integrator.sv
// Pose integrator: rolls velocity-command items out into a pose trajectory.
//
// The cmd channel takes one item per time step (forward, lateral and turn
// rates, first and last flags). The pose channel returns one item per
// command with x, y, heading and the end-of-run flag. The configuration
// port writes step time, start pose and holonomic mode, which the user must
// write only while the block idles; the block itself does not enforce it.
// An item is handled by one CORDIC rotation, one iteration per cycle, and
// then by scale steps on a shared 32 by 32 bit multiplier that removes the
// CORDIC gain, scales by the step time and turns the turn rate into a
// heading change. It passes the rotate, scale and write states before a
// next item is accepted; a pose register holds the result. If the receiver
// stalls, the next item is still taken and computed, and it waits in the
// final step until the register is free. Reset clears the pose to zero,
// loads the default step time and empties the output.
module trajectory_pose_integrator
	import tpi_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	tpi_stream_if.sink                 cmd,
	tpi_stream_if.source               pose
);

	localparam int ITER_WIDTH = $clog2(CORDIC_STEPS);
	localparam int SAT_WIDTH  = (POSITION_WIDTH > 32) ? POSITION_WIDTH : 32;
	localparam int SUM_WIDTH  =
		((POSITION_WIDTH > DELTA_WIDTH) ? POSITION_WIDTH : DELTA_WIDTH) + 1;
	localparam logic signed [POSITION_WIDTH-1:0] POS_MAX =
		{1'b0, {(POSITION_WIDTH-1){1'b1}}};
	localparam logic signed [POSITION_WIDTH-1:0] POS_MIN =
		{1'b1, {(POSITION_WIDTH-1){1'b0}}};
	localparam logic [63:0] ROUND_POS = 64'h1 << 41;
	localparam logic [63:0] ROUND_ANG = 64'h1 << 20;

	logic [15:0]        step_time_q;
	logic signed [31:0] start_x_q;
	logic signed [31:0] start_y_q;
	logic signed [15:0] start_heading_q;
	logic               holonomic_q;

	state_t      state_q, state_d;
	scale_step_t step_q;
	logic [ITER_WIDTH-1:0] iter_q;

	logic signed [POSITION_WIDTH-1:0] x_acc_q, y_acc_q;
	logic signed [15:0]               heading_acc_q;
	logic signed [RATE_WIDTH-1:0]     wz_q;
	logic                             last_q;
	logic signed [ROT_WIDTH-1:0]      rx_q, ry_q;
	logic signed [ANG_WIDTH-1:0]      rz_q;
	logic [63:0] mul_q;
	logic [31:0] hm_q;
	logic [63:0] sx_q, sy_q, tx_q, ty_q, ah_q;
	logic        out_valid_q;
	pose_t       out_q;

	logic        cmd_acc;
	logic        slot_free;
	logic        write_en;
	logic [31:0] mul_a, mul_b;

	logic signed [15:0]          hsel;
	logic                        h_turn;
	logic signed [15:0]          h_adj;
	logic signed [ROT_WIDTH-1:0] vx_w, vy_w;
	logic signed [ANG_WIDTH-1:0] z_init;

	logic signed [ROT_WIDTH-1:0] x_sh, y_sh;
	logic signed [ANG_WIDTH-1:0] atan_w;
	logic [ROT_WIDTH-1:0]        mag_x, mag_y;
	logic [RATE_WIDTH:0]         wz_mag;

	logic [63:0]                      rnd_x, rnd_y, rnd_h;
	logic signed [DELTA_WIDTH-1:0]    dx_s, dy_s;
	logic signed [SUM_WIDTH-1:0]      sum_x, sum_y;
	logic signed [POSITION_WIDTH-1:0] x_new, y_new;
	logic signed [SAT_WIDTH-1:0]      x_out, y_out;
	logic [15:0]                      dh, dh_s;
	logic [15:0]                      heading_new;

	function automatic logic signed [POSITION_WIDTH-1:0] sat_start(
		input logic signed [31:0] v
	);
		logic signed [SAT_WIDTH-1:0] ev;
		logic signed [POSITION_WIDTH-1:0] r;
		ev = SAT_WIDTH'(v);
		if (ev > SAT_WIDTH'(POS_MAX)) begin
			r = POS_MAX;
		end else if (ev < SAT_WIDTH'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = POSITION_WIDTH'(ev);
		end
		return r;
	endfunction

	function automatic logic signed [POSITION_WIDTH-1:0] sat_sum(
		input logic signed [SUM_WIDTH-1:0] v
	);
		logic signed [POSITION_WIDTH-1:0] r;
		if (v > SUM_WIDTH'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < SUM_WIDTH'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = POSITION_WIDTH'(v);
		end
		return r;
	endfunction

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign slot_free = !out_valid_q || pose.ready;

	// Rotation setup from the heading held before this step.
	always_comb begin
		hsel   = cmd.data.first_step ? start_heading_q : heading_acc_q;
		h_turn = (hsel > 16'sd16384) || (hsel < -16'sd16384);
		h_adj  = h_turn ? (hsel + 16'sh8000) : hsel;
		vx_w   = ROT_WIDTH'(cmd.data.speed_forward) <<< GUARD_SHIFT;
		vy_w   = holonomic_q ? (ROT_WIDTH'(cmd.data.speed_lateral) <<< GUARD_SHIFT) : '0;
		z_init = ANG_WIDTH'(h_adj) <<< 16;
	end

	always_comb begin
		x_sh   = rx_q >>> iter_q;
		y_sh   = ry_q >>> iter_q;
		atan_w = signed'(ANG_WIDTH'(atan_unit(ATAN_IDX_WIDTH'(iter_q))));
		mag_x  = rx_q[ROT_WIDTH-1] ? unsigned'(-rx_q) : unsigned'(rx_q);
		mag_y  = ry_q[ROT_WIDTH-1] ? unsigned'(-ry_q) : unsigned'(ry_q);
		wz_mag = wz_q[RATE_WIDTH-1] ? unsigned'(-(RATE_WIDTH+1)'(wz_q))
			: unsigned'((RATE_WIDTH+1)'(wz_q));
	end

	// Final step: rounding, sign, saturation and heading wrap.
	always_comb begin
		rnd_x = tx_q + ROUND_POS;
		rnd_y = ty_q + ROUND_POS;
		rnd_h = ah_q + ROUND_ANG;
		dx_s  = rx_q[ROT_WIDTH-1] ? -signed'({1'b0, rnd_x[63:42]}) : signed'({1'b0, rnd_x[63:42]});
		dy_s  = ry_q[ROT_WIDTH-1] ? -signed'({1'b0, rnd_y[63:42]}) : signed'({1'b0, rnd_y[63:42]});
		sum_x = SUM_WIDTH'(x_acc_q) + SUM_WIDTH'(dx_s);
		sum_y = SUM_WIDTH'(y_acc_q) + SUM_WIDTH'(dy_s);
		x_new = sat_sum(sum_x);
		y_new = sat_sum(sum_y);
		x_out = SAT_WIDTH'(x_new);
		y_out = SAT_WIDTH'(y_new);
		dh    = rnd_h[36:21];
		dh_s  = wz_q[RATE_WIDTH-1] ? (16'd0 - dh) : dh;
		heading_new = unsigned'(heading_acc_q) + dh_s;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) state_d = ST_ROTATE;
			end
			ST_ROTATE: begin
				if (iter_q == ITER_WIDTH'(CORDIC_STEPS - 1)) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (step_q == SC_H_DRAIN) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready  = (state_q == ST_IDLE);
		write_en   = (state_q == ST_WRITE) && slot_free;
		pose.valid = out_valid_q;
		pose.data  = out_q;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_ROTATE: begin
				mul_a = 32'(wz_mag);
				mul_b = 32'(step_time_q);
			end
			ST_SCALE: begin
				case (step_q)
					SC_X_HI_K:  begin mul_a = mag_x[47:16];          mul_b = GAIN_COMP;  end
					SC_X_LO_K:  begin mul_a = 32'(mag_x[15:0]);      mul_b = GAIN_COMP;  end
					SC_Y_HI_K:  begin mul_a = mag_y[47:16];          mul_b = GAIN_COMP;  end
					SC_X_CHI_T: begin mul_a = sx_q[63:32];           mul_b = 32'(step_time_q); end
					SC_Y_LO_K:  begin mul_a = 32'(mag_y[15:0]);      mul_b = GAIN_COMP;  end
					SC_X_CLO_T: begin mul_a = 32'(sx_q[31:16]);      mul_b = 32'(step_time_q); end
					SC_Y_CHI_T: begin mul_a = sy_q[63:32];           mul_b = 32'(step_time_q); end
					SC_Y_CLO_T: begin mul_a = 32'(sy_q[31:16]);      mul_b = 32'(step_time_q); end
					SC_H_HI_P:  begin mul_a = 32'(hm_q[31:24]);      mul_b = INV_PI_Q32; end
					SC_H_LO_P:  begin mul_a = 32'(hm_q[23:0]);       mul_b = INV_PI_Q32; end
					default:    begin mul_a = '0;                    mul_b = '0;         end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q     <= STEP_TIME_RESET;
			start_x_q       <= '0;
			start_y_q       <= '0;
			start_heading_q <= '0;
			holonomic_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_STEP_TIME:     step_time_q     <= cfg_data[15:0];
				CFG_START_X:       start_x_q       <= signed'(cfg_data[31:0]);
				CFG_START_Y:       start_y_q       <= signed'(cfg_data[31:0]);
				CFG_START_HEADING: start_heading_q <= signed'(cfg_data[15:0]);
				CFG_HOLONOMIC:     holonomic_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= SC_X_HI_K;
			iter_q        <= '0;
			x_acc_q       <= '0;
			y_acc_q       <= '0;
			heading_acc_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_acc) begin
				iter_q <= '0;
				if (cmd.data.first_step) begin
					x_acc_q       <= sat_start(start_x_q);
					y_acc_q       <= sat_start(start_y_q);
					heading_acc_q <= start_heading_q;
				end
			end else if (state_q == ST_ROTATE) begin
				iter_q <= iter_q + 1'b1;
				step_q <= SC_X_HI_K;
			end else if (state_q == ST_SCALE && step_q != SC_H_DRAIN) begin
				step_q <= scale_step_t'(step_q + 4'd1);
			end
			if (write_en) begin
				x_acc_q       <= x_new;
				y_acc_q       <= y_new;
				heading_acc_q <= signed'(heading_new);
				out_valid_q   <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (cmd_acc) begin
			wz_q   <= cmd.data.turn_rate;
			last_q <= cmd.data.last_step;
			rx_q   <= h_turn ? -vx_w : vx_w;
			ry_q   <= h_turn ? -vy_w : vy_w;
			rz_q   <= z_init;
		end else if (state_q == ST_ROTATE) begin
			if (!rz_q[ANG_WIDTH-1]) begin
				rx_q <= rx_q - y_sh;
				ry_q <= ry_q + x_sh;
				rz_q <= rz_q - atan_w;
			end else begin
				rx_q <= rx_q + y_sh;
				ry_q <= ry_q - x_sh;
				rz_q <= rz_q + atan_w;
			end
		end
		if (state_q == ST_SCALE) begin
			case (step_q)
				SC_X_HI_K:  hm_q <= mul_q[31:0];
				SC_X_LO_K:  sx_q <= mul_q;
				SC_Y_HI_K:  sx_q <= sx_q + (mul_q >> 16);
				SC_X_CHI_T: sy_q <= mul_q;
				SC_Y_LO_K:  tx_q <= mul_q << 16;
				SC_X_CLO_T: sy_q <= sy_q + (mul_q >> 16);
				SC_Y_CHI_T: tx_q <= tx_q + mul_q;
				SC_Y_CLO_T: ty_q <= mul_q << 16;
				SC_H_HI_P:  ty_q <= ty_q + mul_q;
				SC_H_LO_P:  ah_q <= mul_q;
				SC_H_DRAIN: ah_q <= ah_q + (mul_q >> 24);
				default: ;
			endcase
		end
		if (write_en) begin
			out_q.pos_x      <= x_out[31:0];
			out_q.pos_y      <= y_out[31:0];
			out_q.heading    <= signed'(heading_new);
			out_q.end_of_run <= last_q;
		end
	end

endmodule

FILE: test/tb_trajectory_pose_integrator.sv
// Self-checking testbench for the pose integrator: stimulus, pose prediction and checking.
module tb_trajectory_pose_integrator
	import tpi_pkg::*;
();

	localparam int CORDIC_ITERS = CORDIC_STEPS_DEF;
	localparam int QUARTER_TURN = 16384;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 48;
	localparam int MAX_REPORTS  = 60;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS  = 105;

	class pose_scoreboard;
		bit [15:0] step_time;
		bit [31:0] start_x;
		bit [31:0] start_y;
		bit [15:0] start_heading;
		bit        holonomic;
		bit [15:0] heading_acc;
		longint    x_acc;
		longint    y_acc;
		longint    atan_z [CORDIC_ITERS];
		pose_t     expected_poses [$];
		int        errors;

		function new();
			step_time     = STEP_TIME_RESET;
			start_x       = '0;
			start_y       = '0;
			start_heading = '0;
			holonomic     = 1'b0;
			heading_acc   = '0;
			x_acc         = 0;
			y_acc         = 0;
			errors        = 0;
			atan_z = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861};
		endfunction

		function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
				logic [CFG_DATA_WIDTH-1:0] data);
			case (idx)
				CFG_STEP_TIME: begin
					step_time = data[15:0];
				end
				CFG_START_X: begin
					start_x = data;
				end
				CFG_START_Y: begin
					start_y = data;
				end
				CFG_START_HEADING: begin
					start_heading = data[15:0];
				end
				CFG_HOLONOMIC: begin
					holonomic = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint clamp_pos(longint v);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (POSITION_WIDTH_DEF - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		// Removes the CORDIC gain and scales by the step time, rounding half away from zero.
		function longint scaled_step(longint r);
			bit [63:0] m;
			bit [63:0] c;
			bit [63:0] d;
			m = (r < 0) ? 64'(-r) : 64'(r);
			c = ((m >> 16) * GAIN_COMP + (((m & 64'hFFFF) * GAIN_COMP) >> 16)) >> 16;
			d = (c * step_time + (64'd1 << 41)) >> 42;
			return (r < 0) ? -longint'(d) : longint'(d);
		endfunction

		function void note_cmd(cmd_t c);
			longint    x;
			longint    y;
			longint    z;
			longint    dx;
			longint    dy;
			longint    p;
			shortint   h;
			bit [15:0] flipped;
			bit [63:0] m;
			bit [63:0] a;
			bit [63:0] d;
			pose_t     e;
			if (c.first_step) begin
				x_acc = clamp_pos(longint'($signed(start_x)));
				y_acc = clamp_pos(longint'($signed(start_y)));
				heading_acc = start_heading;
			end
			x = longint'(c.speed_forward) * (longint'(1) <<< GUARD_SHIFT);
			y = holonomic ? longint'(c.speed_lateral) * (longint'(1) <<< GUARD_SHIFT) : 0;
			h = shortint'(heading_acc);
			if (h > QUARTER_TURN || h < -QUARTER_TURN) begin
				x = -x;
				y = -y;
				flipped = heading_acc + 16'h8000;
				h = shortint'(flipped);
			end
			z = longint'(h) * 65536;
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atan_z[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atan_z[i];
				end
			end
			x_acc = clamp_pos(x_acc + scaled_step(x));
			y_acc = clamp_pos(y_acc + scaled_step(y));
			p = longint'(c.turn_rate) * longint'(step_time);
			m = (p < 0) ? 64'(-p) : 64'(p);
			a = (m >> 24) * INV_PI_Q32 + (((m & 64'hFFFFFF) * INV_PI_Q32) >> 24);
			d = (a + (64'd1 << (RATE_WIDTH + 4))) >> (RATE_WIDTH + 5);
			if (p < 0)
				d = -d;
			heading_acc = heading_acc + d[15:0];
			e.pos_x = x_acc[31:0];
			e.pos_y = y_acc[31:0];
			e.heading = heading_acc;
			e.end_of_run = c.last_step;
			expected_poses.push_back(e);
		endfunction

		function void mismatch(string field, longint want, longint got);
			if (errors < MAX_REPORTS)
				$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (expected_poses.size() == 0) begin
				if (errors < MAX_REPORTS)
					$error("pose item with no command waiting for it");
				errors++;
				return;
			end
			e = expected_poses.pop_front();
			if (got.pos_x !== e.pos_x)
				mismatch("pos_x", e.pos_x, got.pos_x);
			if (got.pos_y !== e.pos_y)
				mismatch("pos_y", e.pos_y, got.pos_y);
			if (got.heading !== e.heading)
				mismatch("heading", e.heading, got.heading);
			if (got.end_of_run !== e.end_of_run)
				mismatch("end_of_run", e.end_of_run, got.end_of_run);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	bit                         calm = 1'b0;
	int                         cycles = 0;
	pose_scoreboard             sb;

	tpi_stream_if #(.payload_t(cmd_t))  cmd_if ();
	tpi_stream_if #(.payload_t(pose_t)) pose_if ();

	trajectory_pose_integrator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_if),
		.pose      (pose_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && pose_if.valid === 1'b1 && pose_if.ready === 1'b1)
			sb.check_pose(pose_if.data);
	end

	initial begin
		int stall;
		pose_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				pose_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pose_if.ready <= 1'b1;
			@(posedge clk);
			while (pose_if.valid !== 1'b1)
				@(posedge clk);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= c;
		@(posedge clk);
		while (cmd_if.ready !== 1'b1)
			@(posedge clk);
		sb.note_cmd(c);
	endtask

	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (sb.expected_poses.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_rate();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_start();
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF - $urandom_range(0, 1 << 22);
			1: return 32'h80000000 + $urandom_range(0, 1 << 22);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [15:0] boundary_heading [5];
		cmd_t        c;
		int          sent;
		int          len;
		boundary_heading = '{16'h4000, 16'h4001, 16'hC000, 16'hBFFF, 16'h7FFF};
		sb = new();
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		cmd_if.valid <= 1'b0;
		cmd_if.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Integration from the cleared state before any first step, default settings.
		send_cmd(cmd_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0});
		send_cmd(cmd_t'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0});
		send_cmd(cmd_t'{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1});

		// Start heading at minus pi, holonomic, longest step, y starting at its minimum.
		wait_idle();
		write_reg(CFG_STEP_TIME, 32'h0000FFFF);
		write_reg(CFG_START_X, 32'h7FFF0000);
		write_reg(CFG_START_Y, 32'h80000000);
		write_reg(CFG_START_HEADING, 32'h00008000);
		write_reg(CFG_HOLONOMIC, 32'h1);
		for (int i = int'(CFG_HOLONOMIC) + 1; i < (1 << CFG_INDEX_WIDTH); i++)
			write_reg(CFG_INDEX_WIDTH'(i), '1);
		send_cmd(cmd_t'{16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 1'b0});
		send_cmd(cmd_t'{16'sh8000, 16'sh8000, 16'sh4000, 1'b0, 1'b0});
		send_cmd(cmd_t'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0});
		send_cmd(cmd_t'{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 1'b1});

		// Both positions pushed past their maximum, lateral rate ignored in differential mode.
		wait_idle();
		write_reg(CFG_START_X, 32'h7FFFFFFF);
		write_reg(CFG_START_Y, 32'h7FFFFFFF);
		write_reg(CFG_START_HEADING, 32'h00002000);
		write_reg(CFG_HOLONOMIC, 32'h0);
		send_cmd(cmd_t'{16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 1'b0});
		send_cmd(cmd_t'{16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 1'b1});

		// A zero step time leaves the start pose unchanged.
		wait_idle();
		write_reg(CFG_STEP_TIME, 32'h0);
		send_cmd(cmd_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1});

		// Headings on either side of the quarter turns and next to pi.
		wait_idle();
		write_reg(CFG_STEP_TIME, 32'h0000FFFF);
		write_reg(CFG_START_X, 32'h0);
		write_reg(CFG_START_Y, 32'h0);
		write_reg(CFG_HOLONOMIC, 32'h1);
		foreach (boundary_heading[k]) begin
			wait_idle();
			write_reg(CFG_START_HEADING, {16'h0000, boundary_heading[k]});
			send_cmd(cmd_t'{16'sh7FFF, 16'shCFC7, 16'sh0000, 1'b1, 1'b1});
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			calm = (ph == 2) || ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 4))
				0: write_reg(CFG_STEP_TIME, 32'h0);
				1: write_reg(CFG_STEP_TIME, 32'h0000FFFF);
				2: write_reg(CFG_STEP_TIME, {16'h0000, STEP_TIME_RESET});
				default: write_reg(CFG_STEP_TIME, $urandom_range(0, 65535));
			endcase
			write_reg(CFG_START_X, rand_start());
			write_reg(CFG_START_Y, rand_start());
			write_reg(CFG_START_HEADING, $urandom_range(0, 65535));
			write_reg(CFG_HOLONOMIC, 32'(ph % 2));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0) begin
					c = cmd_t'{16'($urandom), 16'($urandom), 16'($urandom),
						1'($urandom), 1'($urandom)};
					send_cmd(c);
					sent++;
				end else begin
					len = $urandom_range(1, 24);
					for (int k = 0; k < len; k++) begin
						c.speed_forward = rand_rate();
						c.speed_lateral = rand_rate();
						c.turn_rate     = rand_rate();
						c.first_step    = (k == 0);
						c.last_step     = (k == len - 1);
						send_cmd(c);
					end
					sent += len;
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_poses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: trajectory_pose_integrator.f
rtl/tpi_pkg.sv
rtl/tpi_stream_if.sv
rtl/trajectory_pose_integrator.sv
test/tb_trajectory_pose_integrator.sv
